// File: design/pwf_pkg.sv
package pwf_pkg;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FORCE_MODE = 3'd0;
    localparam logic [2:0] REG_FORCE_GAIN = 3'd1;
    localparam logic [2:0] REG_WIND_DIR_X = 3'd2;
    localparam logic [2:0] REG_WIND_DIR_Y = 3'd3;
    localparam logic [2:0] REG_WIND_DIR_Z = 3'd4;
    localparam logic [2:0] REG_CENTER_X   = 3'd5;
    localparam logic [2:0] REG_CENTER_Y   = 3'd6;
    localparam logic [2:0] REG_CENTER_Z   = 3'd7;

    // Force modes
    localparam logic MODE_WIND  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [23:0]        time_step;
    } pwf_in_t;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               saturated;
    } pwf_out_t;

endpackage

// File: design/pwf_sqrt.sv
// Pipelined integer square root: one result bit per stage, 32 stages.
module pwf_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);

    logic [63:0] rad_reg  [0:31];
    logic [33:0] rem_reg  [0:31];
    logic [31:0] root_reg [0:31];

    for (genvar k = 0; k < 32; k++) begin : g_stage
        logic [63:0] rad_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] rem_t;
        logic [35:0] test;
        logic        ge;
        logic [35:0] rem_sub;

        if (k == 0) begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down two radicand bits, try the next root bit
        assign rem_t   = {rem_in, rad_in[63:62]};
        assign test    = {2'b00, root_in, 2'b01};
        assign ge      = (rem_t >= test);
        assign rem_sub = ge ? (rem_t - test) : rem_t;

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {rad_in[61:0], 2'b00};
                rem_reg[k]  <= rem_sub[33:0];
                root_reg[k] <= {root_in[30:0], ge};
            end
        end
    end

    assign root = root_reg[31];

endmodule

// File: design/pwf_div.sv
// Pipelined restoring divider for three numerators over one divisor.
// Numerators never exceed the divisor, so the quotient has FRAC_BITS+1 bits.
module pwf_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [2:0][31:0]            num,
    input  logic [31:0]                 den,
    output logic [2:0][FRAC_BITS:0]     quo
);

    localparam int QW = FRAC_BITS + 1;

    logic [2:0][31:0]   part_reg [0:QW-1];
    logic [2:0][QW-1:0] q_reg    [0:QW-1];
    logic [31:0]        den_reg  [0:QW-1];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [2:0][31:0]   part_in;
        logic [2:0][QW-1:0] q_in;
        logic [31:0]        den_in;
        logic [2:0][31:0]   part_next;
        logic [2:0][QW-1:0] q_next;

        if (j == 0) begin : g_first
            assign part_in = '0;
            assign q_in    = '0;
            assign den_in  = den;
        end else begin : g_next
            assign part_in = part_reg[j-1];
            assign q_in    = q_reg[j-1];
            assign den_in  = den_reg[j-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        always_comb begin
            logic [32:0] t;
            logic        ge;
            for (int i = 0; i < 3; i++) begin
                if (j == 0) begin
                    t = {1'b0, num[i]};
                end else begin
                    t = {part_in[i], 1'b0};
                end
                ge = (t >= {1'b0, den_in});
                part_next[i] = ge ? 32'(t - {1'b0, den_in}) : t[31:0];
                q_next[i]    = {q_in[i][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                part_reg[j] <= part_next;
                q_reg[j]    <= q_next;
                den_reg[j]  <= den_in;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// File: design/particle_wind_point_force_core.sv
// The path from input accept to m_valid runs through the 32-stage square root and the
// FRAC_BITS+1 stage divider, whose quotient point mode uses.
// Throughput: one item per cycle while s_ready is high; both modes take the same path and latency.
// A two-entry output (register plus skid) keeps s_ready registered.
// Reset (aresetn low, synchronous) clears all valid bits and the configuration registers to 0.
module particle_wind_point_force_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pwf_pkg::pwf_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pwf_pkg::pwf_out_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pwf_pkg::ADDR_W-1:0]    paddr,
    input  logic [pwf_pkg::DATA_W-1:0]    pwdata,
    output logic [pwf_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    import pwf_pkg::*;

    localparam int SW     = 57 - FRAC_BITS;
    localparam int QW     = FRAC_BITS + 1;
    localparam int SQ_LAT = 32;
    localparam int SD_LAT = SQ_LAT + QW;
    localparam int HW     = SW - 20;
    localparam int PRW    = 32 + SW;
    localparam int DW     = PRW - FRAC_BITS;

    typedef struct packed {
        logic [2:0][31:0]     vel;
        logic signed [SW-1:0] s;
        logic [2:0]           neg;
        logic                 zero;
    } side_t;

    // ---------------- configuration registers ----------------
    logic               force_mode_reg;
    logic signed [31:0] force_gain_reg;
    logic [2:0][31:0]   wind_reg;
    logic [2:0][31:0]   center_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            force_mode_reg <= MODE_WIND;
            force_gain_reg <= '0;
            wind_reg       <= '0;
            center_reg     <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_FORCE_MODE: force_mode_reg <= pwdata[0];
                REG_FORCE_GAIN: force_gain_reg <= pwdata;
                REG_WIND_DIR_X: wind_reg[0]    <= pwdata;
                REG_WIND_DIR_Y: wind_reg[1]    <= pwdata;
                REG_WIND_DIR_Z: wind_reg[2]    <= pwdata;
                REG_CENTER_X:   center_reg[0]  <= pwdata;
                REG_CENTER_Y:   center_reg[1]  <= pwdata;
                REG_CENTER_Z:   center_reg[2]  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_FORCE_MODE: prdata = {31'd0, force_mode_reg};
            REG_FORCE_GAIN: prdata = force_gain_reg;
            REG_WIND_DIR_X: prdata = wind_reg[0];
            REG_WIND_DIR_Y: prdata = wind_reg[1];
            REG_WIND_DIR_Z: prdata = wind_reg[2];
            REG_CENTER_X:   prdata = center_reg[0];
            REG_CENTER_Y:   prdata = center_reg[1];
            REG_CENTER_Z:   prdata = center_reg[2];
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic skid_valid_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [SD_LAT-1:0] vl_reg;
    logic vm0_reg, vm1_reg, vm2_reg, vm3_reg;

    // Advance valid bits together with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            vl_reg  <= '0;
            vm0_reg <= 1'b0;
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
            vm3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            vl_reg  <= {vl_reg[SD_LAT-2:0], v7_reg};
            vm0_reg <= vl_reg[SD_LAT-1];
            vm1_reg <= vm0_reg;
            vm2_reg <= vm1_reg;
            vm3_reg <= vm2_reg;
        end
    end

    // ---------------- stage 1: scale product, offsets ----------------
    logic signed [56:0] prod1_reg;
    logic signed [56:0] prod1_next;
    logic [2:0][32:0]   d1_reg;
    logic [2:0][32:0]   d1_next;
    logic [2:0][31:0]   vel1_reg;
    logic [2:0][31:0]   pos_in;

    assign pos_in     = {s_data.pos_z, s_data.pos_y, s_data.pos_x};
    assign prod1_next = force_gain_reg * $signed({1'b0, s_data.time_step});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1_next[i] = {center_reg[i][31], center_reg[i]} - {pos_in[i][31], pos_in[i]};
        end
    end

    // ---------------- stage 2: force scale, magnitudes ----------------
    logic [2:0][32:0] m2_next;
    side_t            side2_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m2_next[i] = d1_reg[i][32] ? (33'd0 - d1_reg[i]) : d1_reg[i];
        end
        side2_next.vel  = vel1_reg;
        side2_next.s    = prod1_reg[56:FRAC_BITS];
        side2_next.neg  = {d1_reg[2][32], d1_reg[1][32], d1_reg[0][32]};
        side2_next.zero = 1'b0;
    end

    // ---------------- stage 3: largest magnitude ----------------
    logic [2:0][32:0] m2_reg, m3_reg, m4_reg;
    side_t            side2_reg, side3_reg, side4_reg, side5_reg, side6_reg, side7_reg;
    logic [32:0]      mx3_reg;
    logic [32:0]      mx3_next;

    always_comb begin
        mx3_next = m2_reg[0];
        for (int i = 1; i < 3; i++) begin
            if (m2_reg[i] > mx3_next) begin
                mx3_next = m2_reg[i];
            end
        end
    end

    // ---------------- stage 4: normalize shift ----------------
    logic       big4_reg;
    logic [4:0] lz4_reg;
    logic [4:0] lz4_next;
    side_t      side4_next;

    always_comb begin
        lz4_next = '0;
        for (int b = 0; b < 31; b++) begin
            if (mx3_reg[b]) begin
                lz4_next = 5'(30 - b);
            end
        end
        side4_next      = side3_reg;
        side4_next.zero = (mx3_reg == '0);
    end

    // ---------------- stage 5: normalized magnitudes ----------------
    logic [2:0][31:0] n5_next;
    logic [2:0][31:0] n5_reg, n6_reg, n7_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_next[i] = big4_reg ? m4_reg[i][32:1] : (m4_reg[i][31:0] << lz4_reg);
        end
    end

    // ---------------- stage 6/7: squares and their sum ----------------
    logic [2:0][63:0] sq6_reg;
    logic [63:0]      sum7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod1_reg <= prod1_next;
            d1_reg    <= d1_next;
            vel1_reg  <= {s_data.vel_z, s_data.vel_y, s_data.vel_x};
            m2_reg    <= m2_next;
            side2_reg <= side2_next;
            mx3_reg   <= mx3_next;
            m3_reg    <= m2_reg;
            side3_reg <= side2_reg;
            big4_reg  <= mx3_reg[32] | mx3_reg[31];
            lz4_reg   <= lz4_next;
            m4_reg    <= m3_reg;
            side4_reg <= side4_next;
            n5_reg    <= n5_next;
            side5_reg <= side4_reg;
            for (int i = 0; i < 3; i++) begin
                sq6_reg[i] <= n5_reg[i] * n5_reg[i];
            end
            n6_reg    <= n5_reg;
            side6_reg <= side5_reg;
            sum7_reg  <= sq6_reg[0] + sq6_reg[1] + sq6_reg[2];
            n7_reg    <= n6_reg;
            side7_reg <= side6_reg;
        end
    end

    // ---------------- length and unit vector ----------------
    logic [31:0]      len;
    logic [2:0][QW-1:0] quo;
    side_t            sd_reg [0:SD_LAT-1];
    logic [2:0][31:0] nl_reg [0:SQ_LAT-1];

    pwf_sqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .rad  (sum7_reg),
        .root (len)
    );

    pwf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk (aclk),
        .en   (adv),
        .num  (nl_reg[SQ_LAT-1]),
        .den  (len),
        .quo  (quo)
    );

    // Hold side data alongside the root and divider stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            sd_reg[0] <= side7_reg;
            nl_reg[0] <= n7_reg;
            for (int k = 1; k < SD_LAT; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
            for (int k = 1; k < SQ_LAT; k++) begin
                nl_reg[k] <= nl_reg[k-1];
            end
        end
    end

    // ---------------- stage M0: pick multiplier operand ----------------
    logic [2:0][31:0] a0_next;
    logic [2:0][31:0] a0_reg;
    side_t            sdo;
    side_t            sm0_reg, sm1_reg;

    assign sdo = sd_reg[SD_LAT-1];

    always_comb begin
        logic [31:0] qx;
        for (int i = 0; i < 3; i++) begin
            qx = {{(32-QW){1'b0}}, quo[i]};
            if (force_mode_reg == MODE_WIND) begin
                a0_next[i] = wind_reg[i];
            end else if (sdo.zero) begin
                a0_next[i] = '0;
            end else begin
                a0_next[i] = sdo.neg[i] ? (32'd0 - qx) : qx;
            end
        end
    end

    // ---------------- stage M1/M2: split product ----------------
    logic signed [52:0]     plo_reg [0:2];
    logic signed [31+HW:0]  phi_reg [0:2];
    logic signed [PRW-1:0]  full_reg [0:2];
    logic [2:0][31:0]       velm2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            a0_reg  <= a0_next;
            sm0_reg <= sdo;
            for (int i = 0; i < 3; i++) begin
                plo_reg[i] <= $signed(a0_reg[i]) * $signed({1'b0, sm0_reg.s[19:0]});
                phi_reg[i] <= $signed(a0_reg[i]) * $signed(sm0_reg.s[SW-1:20]);
                full_reg[i] <= $signed({phi_reg[i], 20'd0}) + PRW'(plo_reg[i]);
            end
            sm1_reg   <= sm0_reg;
            velm2_reg <= sm1_reg.vel;
        end
    end

    // ---------------- stage M3: add and saturate ----------------
    pwf_out_t out3_next;
    pwf_out_t out3_reg;

    always_comb begin
        logic signed [DW:0]   sum;
        logic [2:0][31:0]     nv;
        logic                 sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sum = (DW+1)'($signed(velm2_reg[i])) + (DW+1)'($signed(full_reg[i][PRW-1:FRAC_BITS]));
            if (sum[DW:31] != {(DW-30){sum[DW]}}) begin
                sat   = 1'b1;
                nv[i] = sum[DW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                nv[i] = sum[31:0];
            end
        end
        out3_next.new_vel_x = nv[0];
        out3_next.new_vel_y = nv[1];
        out3_next.new_vel_z = nv[2];
        out3_next.saturated = sat;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out3_reg <= out3_next;
        end
    end

    // ---------------- output register and skid ----------------
    logic     m_valid_reg;
    pwf_out_t m_data_reg;
    pwf_out_t skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg | vm3_reg;
            skid_valid_reg <= 1'b0;
        end else if (vm3_reg && adv) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Drain skid first, then take the pipeline's last stage
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_reg : out3_reg;
        end else if (vm3_reg && adv) begin
            skid_reg <= out3_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/pwf_checker.sv
module pwf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input pwf_pkg::pwf_out_t m_data
);

    import pwf_pkg::*;

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // Input side closes only behind a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready fell without a stalled result");

    // While input side is closed a result is on offer
    a_ready_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no result pending");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty after reset");

endmodule

bind particle_wind_point_force_core pwf_checker u_pwf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
